FILE: hdl/temloc_pkg.sv
// Shared types, constants and codes of the track event map localizer.
// Used by every module of the block; depends on nothing.
package temloc_pkg;

    localparam int DEF_MAP_DEPTH     = 64;
    localparam int DEF_HISTORY_DEPTH = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [15:0] FALLBACK_RESET = 16'd128;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_EVENT = 2'd1;
    localparam logic [1:0] FUNC_LOSE  = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic [1:0] SYNC_IN      = 2'd0;
    localparam logic [1:0] SYNC_PARTIAL = 2'd1;
    localparam logic [1:0] SYNC_FULL    = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EVENT,
        OP_LOSE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [30:0] distance;
        logic [15:0] velocity;
        logic [1:0]  event_kind;
        logic        partial;
    } req_t;

    typedef struct packed {
        logic [15:0] velocity_out;
        logic [1:0]  sync_state;
        logic [5:0]  active_index;
        logic        overflow;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic [30:0] distance;
        logic [15:0] velocity;
        logic [1:0]  event_kind;
        logic        partial;
    } cmd_t;

    typedef struct packed {
        logic [31:0] position;
        logic [15:0] speed;
        logic [1:0]  kind;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EV_NEXT,
        ST_Q_N0,
        ST_Q_N1,
        ST_Q_RD,
        ST_Q_CHK,
        ST_R_PASS,
        ST_R_ITER,
        ST_M_RD,
        ST_M_CHK,
        ST_M_AFTER,
        ST_R_END,
        ST_R_FINAL,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/temloc_front.sv
// Front part: accepts requests, decodes the function code and queues commands.
// Depends on temloc_pkg.
module temloc_front
    import temloc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic cmd_valid,
    output cmd_t cmd,
    input  logic cmd_pop
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          queue_reg [QUEUE_DEPTH];
    logic [QW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push;
    cmd_t          new_cmd;

    assign busy      = (count_reg == NW'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rp_reg];

    always_comb
    begin
        new_cmd.distance   = request.distance;
        new_cmd.velocity   = request.velocity;
        new_cmd.event_kind = request.event_kind;
        new_cmd.partial    = request.partial;
        case (request.func)
            FUNC_LOAD:  new_cmd.op = OP_LOAD;
            FUNC_EVENT: new_cmd.op = OP_EVENT;
            FUNC_LOSE:  new_cmd.op = OP_LOSE;
            FUNC_QUERY: new_cmd.op = OP_QUERY;
            default:    new_cmd.op = OP_QUERY;
        endcase
    end

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (push)
        begin
            wp_next = (wp_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rp_next = (rp_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wp_reg] <= new_cmd;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> count_reg != '0)
        else $error("Command popped from an empty queue.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(QUEUE_DEPTH))
        else $error("Queue count beyond depth.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a push.");

endmodule

FILE: hdl/temloc_back.sv
// Back part: holds the track map memory and event history and carries out
// each queued command with a sequencer. Depends on temloc_pkg.
module temloc_back
    import temloc_pkg::*;
#(
    parameter int MAP_DEPTH     = DEF_MAP_DEPTH,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        result_valid,
    output rsp_t        result
);

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CW = $clog2(MAP_DEPTH + 1);
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int KW = $clog2(HISTORY_DEPTH + 1);

    state_t state_reg, state_next, ret_reg, ret_next;
    cmd_t   cmd_reg, cmd_next;

    logic [15:0]        fb_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [31:0]        total_reg, total_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic signed [32:0] off_reg, off_next;
    logic [1:0]         sync_reg, sync_next;
    logic [30:0]        hp_reg [HISTORY_DEPTH];
    logic [30:0]        hp_next [HISTORY_DEPTH];
    logic [1:0]         hk_reg [HISTORY_DEPTH];
    logic [1:0]         hk_next [HISTORY_DEPTH];
    logic [KW-1:0]      hlen_reg, hlen_next;

    logic [AW-1:0] sidx_reg, sidx_next;
    logic [CW-1:0] si_reg, si_next;
    logic          sfound_reg, sfound_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [31:0]   fpos_reg, fpos_next;
    logic [1:0]    fkind_reg, fkind_next;

    logic [KW-1:0] k_reg, k_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] lidx_reg, lidx_next;
    logic [31:0]   lpos_reg, lpos_next;
    logic [31:0]   spos_reg, spos_next;

    logic [HW-1:0] pass_reg, pass_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic [1:0]    hits_reg, hits_next;
    logic [AW-1:0] rfound_reg, rfound_next;
    logic [31:0]   rfpos_reg, rfpos_next;

    logic [CW-1:0] qi_reg, qi_next;
    logic [AW-1:0] qidx_reg, qidx_next;
    logic [15:0]   vout_reg, vout_next;
    logic          ovf_reg, ovf_next;

    entry_t        mem [MAP_DEPTH];
    entry_t        mem_q;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    entry_t        mem_wdata;

    logic [32:0]        load_sum;
    logic [HW-1:0]      kidx, kprev;
    logic signed [34:0] map_dist;
    logic signed [32:0] meas;
    logic signed [42:0] lhs, rhs;
    logic               dist_bad, m_kind0, m_end, m_mis, m_fail, m_succ;
    logic signed [34:0] q_ahead, n1_ahead;
    logic signed [34:0] pos_ext;
    logic               q_hit, past_n1;
    logic [30:0]        hp0;

    function automatic logic [AW-1:0] step_next(input logic [AW-1:0] from,
                                                input logic [CW-1:0] cnt);
        logic [CW-1:0] inc;
        inc = CW'(from) + CW'(1);
        return (inc == cnt) ? '0 : AW'(inc);
    endfunction

    function automatic logic [AW-1:0] step_prev(input logic [AW-1:0] from,
                                                input logic [CW-1:0] cnt);
        logic [CW-1:0] dec;
        dec = cnt - CW'(1);
        return (from == '0) ? AW'(dec) : from - 1'b1;
    endfunction

    assign load_sum = {1'b0, total_reg} + {2'b0, cmd_reg.distance};
    assign kidx     = HW'(k_reg);
    assign kprev    = kidx - 1'b1;
    assign hp0      = (hlen_reg == '0) ? '0 : hp_reg[0];
    assign pos_ext  = 35'({4'b0, cmd_reg.distance});

    assign map_dist = 35'({3'b0, lpos_reg}) - 35'({3'b0, mem_q.position})
                    + ((m_reg > lidx_reg) ? 35'({3'b0, total_reg}) : 35'sd0);
    assign meas     = 33'({2'b0, hp_reg[kprev]}) - 33'({2'b0, hp_reg[kidx]});
    assign lhs      = 43'(map_dist) * 43'sd95;
    assign rhs      = 43'(meas) * 43'sd100;
    assign dist_bad = lhs > rhs;
    assign m_kind0  = (k_reg == '0) && (mem_q.kind == KIND_NONE);
    assign m_end    = (k_reg == hlen_reg);
    assign m_mis    = (mem_q.kind != hk_reg[kidx]) || ((k_reg != '0) && dist_bad);
    assign m_fail   = m_kind0 || (!m_end && m_mis);
    assign m_succ   = !m_kind0 && m_end;

    assign q_ahead  = 35'({3'b0, mem_q.position})
                    + ((qidx_reg < cur_reg) ? 35'({3'b0, total_reg}) : 35'sd0)
                    + 35'(off_reg);
    assign n1_ahead = 35'({3'b0, fpos_reg})
                    + ((fidx_reg < cur_reg) ? 35'({3'b0, total_reg}) : 35'sd0)
                    + 35'(off_reg);
    assign q_hit    = q_ahead <= pos_ext;
    assign past_n1  = pos_ext > n1_ahead;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (cmd_reg.op)
                    OP_EVENT:
                    begin
                        state_next = (sync_reg == SYNC_FULL) ? ST_R_PASS : ST_SCAN_RD;
                    end
                    OP_QUERY:
                    begin
                        state_next = (sync_reg != SYNC_IN) ? ST_DONE : ST_SCAN_RD;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_SCAN_RD:
            begin
                state_next = (si_reg == cnt_reg) ? ret_reg : ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = (mem_q.kind != KIND_NONE) ? ret_reg : ST_SCAN_RD;
            end
            ST_EV_NEXT:
            begin
                if (!sfound_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (fkind_reg != cmd_reg.event_kind)
                begin
                    state_next = ST_R_PASS;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_N0:  state_next = sfound_reg ? ST_SCAN_RD : ST_DONE;
            ST_Q_N1:  state_next = (sfound_reg && !past_n1) ? ST_Q_RD : ST_DONE;
            ST_Q_RD:  state_next = (qi_reg == cnt_reg) ? ST_DONE : ST_Q_CHK;
            ST_Q_CHK: state_next = q_hit ? ST_DONE : ST_Q_RD;
            ST_R_PASS: state_next = ST_R_ITER;
            ST_R_ITER:
            begin
                state_next = (ri_reg < cnt_reg && hits_reg < 2'd2) ? ST_M_RD : ST_R_END;
            end
            ST_M_RD:  state_next = ST_M_CHK;
            ST_M_CHK:
            begin
                state_next = (m_fail || m_succ) ? ST_R_ITER : ST_SCAN_RD;
            end
            ST_M_AFTER: state_next = ST_M_RD;
            ST_R_END:
            begin
                if (hits_reg != '0 || pass_reg == HW'(HISTORY_DEPTH - 1))
                begin
                    state_next = ST_R_FINAL;
                end
                else
                begin
                    state_next = ST_R_PASS;
                end
            end
            ST_R_FINAL: state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ret_next    = ret_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        off_next    = off_reg;
        sync_next   = sync_reg;
        hp_next     = hp_reg;
        hk_next     = hk_reg;
        hlen_next   = hlen_reg;
        sidx_next   = sidx_reg;
        si_next     = si_reg;
        sfound_next = sfound_reg;
        fidx_next   = fidx_reg;
        fpos_next   = fpos_reg;
        fkind_next  = fkind_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        lidx_next   = lidx_reg;
        lpos_next   = lpos_reg;
        spos_next   = spos_reg;
        pass_next   = pass_reg;
        ri_next     = ri_reg;
        hits_next   = hits_reg;
        rfound_next = rfound_reg;
        rfpos_next  = rfpos_reg;
        qi_next     = qi_reg;
        qidx_next   = qidx_reg;
        vout_next   = vout_reg;
        ovf_next    = ovf_reg;
        cmd_pop     = 1'b0;
        rd_addr     = sidx_reg;
        mem_we      = 1'b0;
        mem_wdata   = '{position: load_sum[31:0], speed: cmd_reg.velocity,
                        kind: cmd_reg.event_kind};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    vout_next = '0;
                    ovf_next  = 1'b0;
                end
            end
            ST_DISPATCH:
            begin
                case (cmd_reg.op)
                    OP_LOAD:
                    begin
                        if (cnt_reg == CW'(MAP_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            if (load_sum[32])
                            begin
                                mem_wdata.position = '1;
                            end
                            total_next = mem_wdata.position;
                            mem_we     = 1'b1;
                            cnt_next   = cnt_reg + 1'b1;
                        end
                    end
                    OP_LOSE:
                    begin
                        if (cmd_reg.partial)
                        begin
                            if (sync_reg == SYNC_IN)
                            begin
                                sync_next = SYNC_PARTIAL;
                            end
                        end
                        else
                        begin
                            sync_next = SYNC_FULL;
                            hlen_next = '0;
                        end
                    end
                    OP_EVENT:
                    begin
                        if (sync_reg == SYNC_FULL)
                        begin
                            if (cmd_reg.event_kind != KIND_NONE)
                            begin
                                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                                begin
                                    hp_next[i] = hp_reg[i-1];
                                    hk_next[i] = hk_reg[i-1];
                                end
                                hp_next[0] = cmd_reg.distance;
                                hk_next[0] = cmd_reg.event_kind;
                                if (hlen_reg != KW'(HISTORY_DEPTH))
                                begin
                                    hlen_next = hlen_reg + 1'b1;
                                end
                            end
                            pass_next = '0;
                        end
                        else
                        begin
                            sidx_next = step_next(cur_reg, cnt_reg);
                            si_next   = '0;
                            ret_next  = ST_EV_NEXT;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (sync_reg != SYNC_IN)
                        begin
                            vout_next = fb_reg;
                        end
                        else
                        begin
                            sidx_next = step_next(cur_reg, cnt_reg);
                            si_next   = '0;
                            ret_next  = ST_Q_N0;
                        end
                    end
                    default: ovf_next = 1'b0;
                endcase
            end
            ST_SCAN_RD:
            begin
                rd_addr = sidx_reg;
                if (si_reg == cnt_reg)
                begin
                    sfound_next = 1'b0;
                end
            end
            ST_SCAN_CHK:
            begin
                if (mem_q.kind != KIND_NONE)
                begin
                    sfound_next = 1'b1;
                    fidx_next   = sidx_reg;
                    fpos_next   = mem_q.position;
                    fkind_next  = mem_q.kind;
                end
                else
                begin
                    si_next   = si_reg + 1'b1;
                    sidx_next = (ret_reg == ST_M_AFTER) ? step_prev(sidx_reg, cnt_reg)
                                                        : step_next(sidx_reg, cnt_reg);
                end
            end
            ST_EV_NEXT:
            begin
                if (sfound_reg)
                begin
                    if (fkind_reg != cmd_reg.event_kind)
                    begin
                        sync_next = SYNC_FULL;
                        hlen_next = '0;
                        if (cmd_reg.event_kind != KIND_NONE)
                        begin
                            hp_next[0] = cmd_reg.distance;
                            hk_next[0] = cmd_reg.event_kind;
                            hlen_next  = KW'(1);
                        end
                        pass_next = '0;
                    end
                    else
                    begin
                        cur_next  = fidx_reg;
                        off_next  = 33'({2'b0, cmd_reg.distance}) - 33'({1'b0, fpos_reg});
                        sync_next = SYNC_IN;
                    end
                end
            end
            ST_Q_N0:
            begin
                if (sfound_reg)
                begin
                    sidx_next = step_next(fidx_reg, cnt_reg);
                    si_next   = '0;
                    ret_next  = ST_Q_N1;
                end
                else
                begin
                    vout_next = fb_reg;
                end
            end
            ST_Q_N1:
            begin
                qi_next   = '0;
                qidx_next = fidx_reg;
                if (!sfound_reg)
                begin
                    vout_next = fb_reg;
                end
                else if (past_n1)
                begin
                    sync_next = SYNC_PARTIAL;
                    vout_next = fb_reg;
                end
            end
            ST_Q_RD:
            begin
                rd_addr = qidx_reg;
                if (qi_reg == cnt_reg)
                begin
                    vout_next = fb_reg;
                end
            end
            ST_Q_CHK:
            begin
                if (q_hit)
                begin
                    vout_next = mem_q.speed;
                end
                else
                begin
                    qi_next   = qi_reg + 1'b1;
                    qidx_next = step_prev(qidx_reg, cnt_reg);
                end
            end
            ST_R_PASS:
            begin
                hits_next = '0;
                ri_next   = '0;
            end
            ST_R_ITER:
            begin
                k_next = '0;
                m_next = AW'(ri_reg);
            end
            ST_M_RD:
            begin
                rd_addr = m_reg;
            end
            ST_M_CHK:
            begin
                if (m_fail)
                begin
                    ri_next = ri_reg + 1'b1;
                end
                else if (m_succ)
                begin
                    ri_next     = ri_reg + 1'b1;
                    hits_next   = hits_reg + 1'b1;
                    rfound_next = AW'(ri_reg);
                    rfpos_next  = (k_reg == '0) ? mem_q.position : spos_reg;
                end
                else
                begin
                    if (k_reg == '0)
                    begin
                        spos_next = mem_q.position;
                    end
                    lpos_next = mem_q.position;
                    lidx_next = m_reg;
                    k_next    = k_reg + 1'b1;
                    sidx_next = step_prev(m_reg, cnt_reg);
                    si_next   = '0;
                    ret_next  = ST_M_AFTER;
                end
            end
            ST_M_AFTER:
            begin
                m_next = fidx_reg;
            end
            ST_R_END:
            begin
                if (hits_reg == '0)
                begin
                    if (hlen_reg != '0)
                    begin
                        hlen_next = hlen_reg - 1'b1;
                    end
                    pass_next = pass_reg + 1'b1;
                end
            end
            ST_R_FINAL:
            begin
                if (hits_reg == 2'd1)
                begin
                    cur_next  = rfound_reg;
                    off_next  = 33'({2'b0, hp0}) - 33'({1'b0, rfpos_reg});
                    sync_next = SYNC_IN;
                end
            end
            default: cmd_pop = 1'b0;
        endcase
    end

    assign result_valid        = (state_reg == ST_DONE);
    assign result.velocity_out = vout_reg;
    assign result.sync_state   = sync_reg;
    assign result.overflow     = ovf_reg;

    always_comb
    begin
        logic [AW+5:0] wide;
        wide = {6'b0, cur_reg};
        result.active_index = wide[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(cnt_reg)] <= mem_wdata;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fb_reg    <= FALLBACK_RESET;
            cnt_reg   <= '0;
            total_reg <= '0;
            cur_reg   <= '0;
            off_reg   <= '0;
            sync_reg  <= SYNC_IN;
            hlen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (cfg_we)
            begin
                fb_reg <= cfg_wdata;
            end
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            cur_reg   <= cur_next;
            off_reg   <= off_next;
            sync_reg  <= sync_next;
            hlen_reg  <= hlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        hp_reg     <= hp_next;
        hk_reg     <= hk_next;
        sidx_reg   <= sidx_next;
        si_reg     <= si_next;
        sfound_reg <= sfound_next;
        fidx_reg   <= fidx_next;
        fpos_reg   <= fpos_next;
        fkind_reg  <= fkind_next;
        k_reg      <= k_next;
        m_reg      <= m_next;
        lidx_reg   <= lidx_next;
        lpos_reg   <= lpos_next;
        spos_reg   <= spos_next;
        pass_reg   <= pass_next;
        ri_reg     <= ri_next;
        hits_reg   <= hits_next;
        rfound_reg <= rfound_next;
        rfpos_reg  <= rfpos_next;
        qi_reg     <= qi_next;
        qidx_reg   <= qidx_next;
        vout_reg   <= vout_next;
        ovf_reg    <= ovf_next;
    end

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("Result strobe held for more than one cycle.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAP_DEPTH))
        else $error("Map entry count beyond depth.");

    a_history_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hlen_reg <= KW'(HISTORY_DEPTH))
        else $error("History length beyond depth.");

    a_sync_code: assert property (@(posedge clk) disable iff (!rst_n)
        sync_reg == SYNC_IN || sync_reg == SYNC_PARTIAL || sync_reg == SYNC_FULL)
        else $error("Invalid sync state.");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> state_reg == ST_DISPATCH)
        else $error("Command taken without dispatch.");

endmodule

FILE: hdl/track_event_map_localizer.sv
// Top level of the track event map localizer: request front end and sequencer.
// Depends on temloc_pkg, temloc_front and temloc_back.
// Load, sync-lost and out-of-sync queries end without a map walk; events and
// queries walk the map, a read state and a check state per entry; a resync runs
// up to HISTORY_DEPTH passes of MAP_DEPTH start points, each walking the history.
// Throughput: one request at a time in the sequencer; a two-entry command queue
// takes requests while it works. Reset clears map count, history and sync state.
module track_event_map_localizer
    import temloc_pkg::*;
#(
    parameter int MAP_DEPTH     = DEF_MAP_DEPTH,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        result_valid,
    output rsp_t        result
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    temloc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    temloc_back #(
        .MAP_DEPTH     (MAP_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
